// ----- src/erjs_pkg.sv -----
// Shared types and constants for the edge reconstruction Jacobi sweep core.
// Used by the top level; the generic RAM does not depend on it.
package erjs_pkg;

	// Fixed field widths of the pixel stream and the configuration port.
	localparam int PIXEL_W     = 32;
	localparam int CHANGE_W    = 32;
	localparam int SUM_W       = 64;
	localparam int POS_W       = 11;
	localparam int CFG_DATA_W  = 11;
	localparam int CFG_INDEX_W = 2;

	// Size registers come out of reset at this value, clamped to the maximum.
	localparam int SIZE_RESET = 1024;

	// Register indexes of the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_COLS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ROWS = 2'd1;

	typedef logic signed [PIXEL_W-1:0] pixel_t;

	// One column of the line buffer: the row above, the row above that,
	// and the edge pixel of the row above.
	typedef struct packed {
		pixel_t center;
		pixel_t above;
		pixel_t edge_val;
	} line_word_t;

	// Position and end-of-sweep mark that travel with a result.
	typedef struct packed {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             last;
	} tag_t;

endpackage

// ----- src/erjs_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package is needed.
module erjs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write when enabled and read every cycle; the read data is registered.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- src/edge_reconstruction_jacobi_sweep_core.sv -----
// Top level of the edge reconstruction Jacobi sweep core.
// Depends on erjs_pkg and instantiates erjs_ram for the line buffer.
//
// Usage:
// Pixels of the old image, halo border included, enter in raster order on the
// in_valid/in_ready channel, each word paired with the edge pixel at the same
// place. For every interior pixel one word leaves on out_valid/out_ready with
// the new pixel floor((up + down + left + right - edge) / 4), its absolute
// change, its interior position, the running maximum change and the
// saturating running sum. last marks the final interior pixel; the running
// values then start over. A word is produced when the pixel below it arrives.
// Throughput is one pixel per cycle while the receiver keeps up, set by the
// one-read, one-write line buffer RAM whose next columns are fetched ahead
// into a small window. A stalled receiver holds the result in the output
// register and the three stages in front of it fill up before in_ready drops.
// After reset and after every write to the columns or rows register, the frame
// restarts at its first pixel; in_ready stays low in the prime states while
// the window is refilled. The line buffer itself is not cleared: every entry
// that feeds a result is written by the first two rows of the frame.
module edge_reconstruction_jacobi_sweep_core import erjs_pkg::*; #(
	parameter int MAX_COLS = 1024,
	parameter int MAX_ROWS = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [PIXEL_W-1:0]     old_value,
	input  logic signed [PIXEL_W-1:0]     edge_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [PIXEL_W-1:0]     new_value,
	output logic [CHANGE_W-1:0]           pixel_change,
	output logic [POS_W-1:0]              out_row,
	output logic [POS_W-1:0]              out_col,
	output logic [CHANGE_W-1:0]           max_change,
	output logic signed [SUM_W-1:0]       pixel_sum,
	output logic                          last,
	input  logic                          cfg_we,
	input  logic [CFG_INDEX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data
);

	localparam int DEPTH    = MAX_COLS + 2;
	localparam int CW       = $clog2(MAX_COLS + 2);
	localparam int RW       = $clog2(MAX_ROWS + 2);
	localparam int COLS_RST = (SIZE_RESET > MAX_COLS) ? MAX_COLS : SIZE_RESET;
	localparam int ROWS_RST = (SIZE_RESET > MAX_ROWS) ? MAX_ROWS : SIZE_RESET;

	// Window refill sequence after a frame restart.
	localparam logic [1:0] ST_PRIME0 = 2'd0;
	localparam logic [1:0] ST_PRIME1 = 2'd1;
	localparam logic [1:0] ST_PRIME2 = 2'd2;
	localparam logic [1:0] ST_RUN    = 2'd3;

	logic [CW-1:0] cols_q;
	logic [RW-1:0] rows_q;
	logic [CW-1:0] cols_new;
	logic [RW-1:0] rows_new;
	logic          cfg_hit;

	logic [1:0]    state_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_adv;
	logic [RW-1:0] row_adv;
	logic [CW-1:0] col_next;
	logic          col_wrap;
	logic          in_acc;

	logic [CW:0]   rd_sum;
	logic [CW:0]   rd_lim;
	logic [CW-1:0] mem_raddr;
	line_word_t    mem_rdata;
	line_word_t    mem_wdata;

	line_word_t    head_q;
	line_word_t    next_q;
	pixel_t        left_q;

	logic          emit;
	tag_t          tag_in;

	logic          adv_out;
	logic          adv3;
	logic          adv2;
	logic          adv1;

	logic          v1_q;
	pixel_t        up_s1;
	pixel_t        down_s1;
	pixel_t        left_s1;
	pixel_t        right_s1;
	pixel_t        edge_s1;
	pixel_t        mid_s1;
	tag_t          tag_s1;

	logic                 v2_q;
	logic signed [34:0]   stencil_sum;
	logic signed [32:0]   quarter;
	pixel_t               nv_c;
	pixel_t               nv_s2;
	pixel_t               mid_s2;
	tag_t                 tag_s2;

	logic                 v3_q;
	logic signed [32:0]   diff;
	logic [32:0]          diff_abs;
	logic [CHANGE_W-1:0]  chg_c;
	pixel_t               nv_s3;
	logic [CHANGE_W-1:0]  chg_s3;
	tag_t                 tag_s3;

	logic                 out_valid_q;
	pixel_t               nv_q;
	logic [CHANGE_W-1:0]  chg_q;
	tag_t                 tag_q;
	logic [CHANGE_W-1:0]  max_out_q;
	logic signed [SUM_W-1:0] sum_out_q;
	logic [CHANGE_W-1:0]  run_max_q;
	logic signed [SUM_W-1:0] run_sum_q;
	logic [CHANGE_W-1:0]  max_next;
	logic signed [SUM_W:0]   sum_wide;
	logic signed [SUM_W-1:0] sum_next;

	// Size registers, clamped to [2, maximum] as they are written.
	always_comb begin
		if (cfg_data < CFG_DATA_W'(2)) begin
			cols_new = CW'(2);
			rows_new = RW'(2);
		end else begin
			cols_new = (int'(cfg_data) > MAX_COLS) ? CW'(MAX_COLS) : CW'(cfg_data);
			rows_new = (int'(cfg_data) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(cfg_data);
		end
	end

	assign cfg_hit = cfg_we && (cfg_index == REG_COLS || cfg_index == REG_ROWS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= CW'(COLS_RST);
			rows_q <= RW'(ROWS_RST);
		end else if (cfg_we && cfg_index == REG_COLS) begin
			cols_q <= cols_new;
		end else if (cfg_we && cfg_index == REG_ROWS) begin
			rows_q <= rows_new;
		end
	end

	// Frame position of the next input word.
	assign col_wrap = ({1'b0, col_q} == ({1'b0, cols_q} + (CW+1)'(1)));
	assign col_adv  = col_wrap ? '0 : col_q + CW'(1);
	always_comb begin
		row_adv = row_q;
		if (col_wrap) begin
			row_adv = ({1'b0, row_q} == ({1'b0, rows_q} + (RW+1)'(1))) ? '0 : row_q + RW'(1);
		end
	end
	assign col_next = in_acc ? col_adv : col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_PRIME0;
			col_q   <= '0;
			row_q   <= '0;
		end else if (cfg_hit) begin
			state_q <= ST_PRIME0;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			case (state_q)
				ST_PRIME0: state_q <= ST_PRIME1;
				ST_PRIME1: state_q <= ST_PRIME2;
				ST_PRIME2: state_q <= ST_RUN;
				ST_RUN:    state_q <= ST_RUN;
				default:   state_q <= ST_PRIME0;
			endcase
			if (in_acc) begin
				col_q <= col_adv;
				row_q <= row_adv;
			end
		end
	end

	// The RAM read runs two columns ahead of the next input, wrapping at the
	// end of the row, so the window always holds columns c and c+1.
	assign rd_sum = {1'b0, col_next} + (CW+1)'(2);
	assign rd_lim = {1'b0, cols_q} + (CW+1)'(2);
	always_comb begin
		case (state_q)
			ST_PRIME0: mem_raddr = '0;
			ST_PRIME1: mem_raddr = CW'(1);
			default:   mem_raddr = (rd_sum >= rd_lim) ? CW'(rd_sum - rd_lim) : CW'(rd_sum);
		endcase
	end

	// The new pixel becomes the row above; the old one moves two rows up.
	assign mem_wdata.center   = old_value;
	assign mem_wdata.above    = head_q.center;
	assign mem_wdata.edge_val = edge_value;

	erjs_ram #(
		.WIDTH($bits(line_word_t)),
		.DEPTH(DEPTH)
	) u_line_ram (
		.clk  (clk),
		.we   (in_acc),
		.waddr(col_q),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Window of the current and the next column, and the left neighbor.
	always_ff @(posedge clk) begin
		if (state_q == ST_PRIME1) begin
			head_q <= mem_rdata;
		end else if (state_q == ST_PRIME2) begin
			next_q <= mem_rdata;
		end else if (in_acc) begin
			head_q <= next_q;
			next_q <= mem_rdata;
			left_q <= head_q.center;
		end
	end

	// Handshake of the four-stage pipeline.
	assign adv_out  = !out_valid_q || out_ready;
	assign adv3     = !v3_q || adv_out;
	assign adv2     = !v2_q || adv3;
	assign adv1     = !v1_q || adv2;
	assign in_ready = (state_q == ST_RUN) && adv1;
	assign in_acc   = in_valid && in_ready;

	// A result exists for every interior column from the third row on.
	assign emit = (row_q >= RW'(2)) && (col_q >= CW'(1)) && (col_q <= cols_q);
	assign tag_in.row  = POS_W'(row_q - RW'(1));
	assign tag_in.col  = POS_W'(col_q);
	assign tag_in.last = ({1'b0, row_q} == ({1'b0, rows_q} + (RW+1)'(1))) && (col_q == cols_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			v3_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv1) begin
				v1_q <= in_acc && emit;
			end
			if (adv2) begin
				v2_q <= v1_q;
			end
			if (adv3) begin
				v3_q <= v2_q;
			end
			if (adv_out) begin
				out_valid_q <= v3_q;
			end
		end
	end

	// Stage 1: stencil operands.
	always_ff @(posedge clk) begin
		if (adv1) begin
			up_s1    <= head_q.above;
			down_s1  <= old_value;
			left_s1  <= left_q;
			right_s1 <= next_q.center;
			edge_s1  <= head_q.edge_val;
			mid_s1   <= head_q.center;
			tag_s1   <= tag_in;
		end
	end

	// Stage 2: five-point sum, floor divide by four, saturate to a pixel.
	assign stencil_sum = 35'(up_s1) + 35'(down_s1) + 35'(left_s1) + 35'(right_s1)
		- 35'(edge_s1);
	assign quarter = stencil_sum[34:2];
	always_comb begin
		if (quarter[32] != quarter[31]) begin
			nv_c = quarter[32] ? {1'b1, {(PIXEL_W-1){1'b0}}} : {1'b0, {(PIXEL_W-1){1'b1}}};
		end else begin
			nv_c = quarter[PIXEL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			nv_s2  <= nv_c;
			mid_s2 <= mid_s1;
			tag_s2 <= tag_s1;
		end
	end

	// Stage 3: absolute change from the old pixel.
	assign diff     = 33'(nv_s2) - 33'(mid_s2);
	assign diff_abs = diff[32] ? 33'(-diff) : 33'(diff);
	assign chg_c    = diff_abs[32] ? '1 : diff_abs[CHANGE_W-1:0];

	always_ff @(posedge clk) begin
		if (adv3) begin
			nv_s3  <= nv_s2;
			chg_s3 <= chg_c;
			tag_s3 <= tag_s2;
		end
	end

	// Output stage: running maximum and saturating running sum.
	assign max_next = (chg_s3 > run_max_q) ? chg_s3 : run_max_q;
	assign sum_wide = 65'(run_sum_q) + 65'(nv_s3);
	always_comb begin
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
			sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sum_next = sum_wide[SUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_max_q <= '0;
			run_sum_q <= '0;
		end else if (cfg_hit) begin
			run_max_q <= '0;
			run_sum_q <= '0;
		end else if (v3_q && adv_out) begin
			run_max_q <= tag_s3.last ? '0 : max_next;
			run_sum_q <= tag_s3.last ? '0 : sum_next;
		end
	end

	always_ff @(posedge clk) begin
		if (v3_q && adv_out) begin
			nv_q      <= nv_s3;
			chg_q     <= chg_s3;
			tag_q     <= tag_s3;
			max_out_q <= max_next;
			sum_out_q <= sum_next;
		end
	end

	assign out_valid    = out_valid_q;
	assign new_value    = nv_q;
	assign pixel_change = chg_q;
	assign out_row      = tag_q.row;
	assign out_col      = tag_q.col;
	assign max_change   = max_out_q;
	assign pixel_sum    = sum_out_q;
	assign last         = tag_q.last;

	// The column counter never passes the right halo column.
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, col_q} <= ({1'b0, cols_q} + (CW+1)'(1)))
		else $error("column counter beyond the right halo column");

	// The look-ahead read never hits the column being written.
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> (mem_raddr != col_q))
		else $error("line buffer read and write at the same column");

	// The running values start over after the last pixel of a sweep.
	a_sweep_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(v3_q && adv_out && tag_s3.last) |=> (run_max_q == '0 && run_sum_q == '0))
		else $error("running values not cleared after the last pixel");

	// A frame restart holds off input while the window refills.
	a_restart_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_hit |=> !in_ready)
		else $error("input taken before the window was refilled");

endmodule
